/* rtl/cbt_pkg.sv */
// ---------------------------------------------------------------------------
// CSMA/CD byte transmitter package
// Shared types, register indexes, result codes and LFSR tap masks.
// ---------------------------------------------------------------------------
package cbt_pkg;

  // Input item as it arrives on the item channel
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       msg_end;
    logic       channel_busy;
    logic       collision_seen;
  } in_item_t;

  // Result item as it leaves on the result channel
  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [3:0] try_number;
    logic       last_of_run;
  } out_item_t;

  // Input kind codes
  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Result kind codes
  localparam logic [1:0] RES_DATA  = 2'd0;
  localparam logic [1:0] RES_JAM   = 2'd1;
  localparam logic [1:0] RES_ABORT = 2'd2;
  localparam logic [1:0] RES_DONE  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_TRIES    = 3'd0,
    REG_POLL_TICKS   = 3'd1,
    REG_WINDOW_TICKS = 3'd2,
    REG_SLOT_TICKS   = 3'd3,
    REG_BACKOFF_CAP  = 3'd4,
    REG_JAM_BYTE     = 3'd5,
    REG_RANDOM_SEED  = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [3:0]  MAX_TRIES_RST    = 4'd10;
  localparam logic [15:0] POLL_TICKS_RST   = 16'd500;
  localparam logic [15:0] WINDOW_TICKS_RST = 16'd200;
  localparam logic [7:0]  SLOT_TICKS_RST   = 8'd10;
  localparam logic [3:0]  BACKOFF_CAP_RST  = 4'd10;
  localparam logic [7:0]  JAM_BYTE_RST     = 8'd126;

  // Largest backoff exponent the hardware supports
  localparam logic [3:0]  EXP_LIMIT = 4'd10;
  localparam int unsigned TIMER_W   = 18;

  // Configuration seen by the engine
  typedef struct packed {
    logic [3:0]  max_tries;
    logic [15:0] poll_ticks;
    logic [15:0] window_ticks;
    logic [7:0]  slot_ticks;
    logic [3:0]  backoff_cap;
    logic [7:0]  jam_byte;
  } cfg_t;

  // Seed write toward the LFSR
  typedef struct packed {
    logic        load;
    logic [15:0] value;
  } seed_load_t;

  // Classified command held in the front queue
  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       msg_end;
    logic       busy;
    logic       coll;
  } cmd_t;

  // Results caused by one command: zero, one or two
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  res0;
    out_item_t  res1;
  } res_group_t;

  // Transmitter phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_POLL    = 2'd1,
    PH_WINDOW  = 2'd2,
    PH_BACKOFF = 2'd3
  } phase_t;

  // Feedback taps for LFSR widths 11 through 32
  localparam logic [31:0] TAP_MASKS [0:21] = '{
    32'h00000500, 32'h00000829, 32'h0000100D, 32'h00002015, 32'h00006000,
    32'h0000D008, 32'h00012000, 32'h00020400, 32'h00040023, 32'h00090000,
    32'h00140000, 32'h00300000, 32'h00420000, 32'h00E10000, 32'h01200000,
    32'h02000023, 32'h04000013, 32'h09000000, 32'h14000000, 32'h20000029,
    32'h48000000, 32'h80200003
  };

endpackage

/* rtl/cbt_front.sv */
// ---------------------------------------------------------------------------
// CSMA/CD transmitter front end
// Accepts input items, classifies them into commands and queues them.
// ---------------------------------------------------------------------------
module cbt_front import cbt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  in_item_t item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  localparam int unsigned DEPTH = 2;

  cmd_t       entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  // Classify the incoming item
  always_comb begin
    cmd_in.op        = (item.kind == KIND_TICK) ? OP_TICK : OP_OFFER;
    cmd_in.data_byte = item.data_byte;
    cmd_in.msg_end   = item.msg_end;
    cmd_in.busy      = item.channel_busy;
    cmd_in.coll      = item.collision_seen;
  end

  assign item_stall = (count == 2'(DEPTH));
  assign push       = item_valid && !item_stall;
  assign cmd_valid  = (count != 2'd0);
  assign pop        = cmd_valid && cmd_take;
  assign cmd        = entries[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= cmd_in;
  end

endmodule

/* rtl/cbt_engine.sv */
// ---------------------------------------------------------------------------
// CSMA/CD transmitter engine
// Runs carrier sense, collision window and backoff; one command per ready cycle.
// ---------------------------------------------------------------------------
module cbt_engine import cbt_pkg::*; #(
  parameter int unsigned LFSR_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  seed_load_t seed,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  input  logic       grp_ready,
  output logic       grp_valid,
  output res_group_t grp
);

  localparam logic [LFSR_WIDTH-1:0] TAPS = LFSR_WIDTH'(TAP_MASKS[LFSR_WIDTH-11]);

  phase_t               phase, phase_next;
  logic [7:0]           held_byte, held_byte_next;
  logic                 held_end, held_end_next;
  logic [3:0]           try_count, try_count_next;
  logic [TIMER_W-1:0]   wait_timer, wait_timer_next;
  logic [LFSR_WIDTH-1:0] lfsr, lfsr_next;
  logic                 discarding, discarding_next;

  logic [LFSR_WIDTH-1:0] lfsr_stepped;
  logic [LFSR_WIDTH-1:0] lfsr_seeded;
  logic [31:0]           seed_wide;
  logic [3:0]            try_inc;
  logic [3:0]            exp_k;
  logic [9:0]            rand_mask;
  logic [9:0]            rand_val;
  logic [TIMER_W-1:0]    backoff_len;
  logic                  consume;
  res_group_t            grp_c;

  function automatic out_item_t make_res(logic [1:0] k, logic [7:0] b, logic [3:0] t);
    out_item_t r;
    r.out_kind    = k;
    r.out_byte    = b;
    r.try_number  = t;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Next LFSR value, zero replaced by one
  always_comb begin
    lfsr_stepped = {lfsr[LFSR_WIDTH-2:0], ^(lfsr & TAPS)};
    if (lfsr_stepped == '0) lfsr_stepped = LFSR_WIDTH'(1);
  end

  // Seed load value, zero replaced by one
  always_comb begin
    seed_wide   = {16'b0, seed.value};
    lfsr_seeded = seed_wide[LFSR_WIDTH-1:0];
    if (lfsr_seeded == '0) lfsr_seeded = LFSR_WIDTH'(1);
  end

  // Backoff length from clamped exponent and stepped LFSR
  always_comb begin
    try_inc = (try_count < 4'd15) ? try_count + 4'd1 : try_count;
    exp_k   = try_inc;
    if (exp_k > cfg.backoff_cap) exp_k = cfg.backoff_cap;
    if (exp_k > EXP_LIMIT)       exp_k = EXP_LIMIT;
    rand_mask   = 10'((11'd1 << exp_k) - 11'd1);
    rand_val    = lfsr_stepped[9:0] & rand_mask;
    backoff_len = TIMER_W'(rand_val * cfg.slot_ticks);
  end

  assign consume   = cmd_valid && grp_ready;
  assign cmd_take  = consume;
  assign grp_valid = consume;
  assign grp       = grp_c;

  // Next state and results for the command at the queue head
  always_comb begin
    phase_next      = phase;
    held_byte_next  = held_byte;
    held_end_next   = held_end;
    try_count_next  = try_count;
    wait_timer_next = wait_timer;
    lfsr_next       = lfsr;
    discarding_next = discarding;
    grp_c           = '0;

    if (cmd.op == OP_OFFER) begin
      if (phase == PH_IDLE) begin
        if (discarding) begin
          if (cmd.msg_end) discarding_next = 1'b0;
        end else begin
          held_byte_next = cmd.data_byte;
          held_end_next  = cmd.msg_end;
          try_count_next = 4'd0;
          if (cmd.busy) begin
            phase_next      = PH_POLL;
            wait_timer_next = TIMER_W'(cfg.poll_ticks);
          end else begin
            grp_c.cnt       = 2'd1;
            grp_c.res0      = make_res(RES_DATA, cmd.data_byte, 4'd0);
            phase_next      = PH_WINDOW;
            wait_timer_next = TIMER_W'(cfg.window_ticks);
          end
        end
      end
    end else if (phase != PH_IDLE) begin
      if (wait_timer > TIMER_W'(1)) begin
        wait_timer_next = wait_timer - TIMER_W'(1);
      end else begin
        wait_timer_next = '0;
        if (phase == PH_WINDOW) begin
          if (!cmd.coll) begin
            grp_c.cnt  = 2'd1;
            grp_c.res0 = make_res(RES_DONE, 8'd0, try_count);
            phase_next = PH_IDLE;
          end else begin
            try_count_next = try_inc;
            grp_c.res0     = make_res(RES_JAM, cfg.jam_byte, try_inc);
            if (try_inc >= cfg.max_tries) begin
              grp_c.cnt       = 2'd2;
              grp_c.res1      = make_res(RES_ABORT, 8'd0, try_inc);
              discarding_next = !held_end;
              phase_next      = PH_IDLE;
            end else begin
              grp_c.cnt       = 2'd1;
              lfsr_next       = lfsr_stepped;
              wait_timer_next = backoff_len;
              phase_next      = PH_BACKOFF;
            end
          end
        end else if (cmd.busy) begin
          phase_next      = PH_POLL;
          wait_timer_next = TIMER_W'(cfg.poll_ticks);
        end else begin
          grp_c.cnt       = 2'd1;
          grp_c.res0      = make_res(RES_DATA, held_byte, try_count);
          phase_next      = PH_WINDOW;
          wait_timer_next = TIMER_W'(cfg.window_ticks);
        end
      end
    end

    // Mark the final result of the run
    if (grp_c.cnt == 2'd1) grp_c.res0.last_of_run = 1'b1;
    if (grp_c.cnt == 2'd2) grp_c.res1.last_of_run = 1'b1;
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (consume) begin
      phase <= phase_next;
    end
  end

  // Transfer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte  <= 8'd0;
      held_end   <= 1'b0;
      try_count  <= 4'd0;
      wait_timer <= '0;
      discarding <= 1'b0;
    end else if (consume) begin
      held_byte  <= held_byte_next;
      held_end   <= held_end_next;
      try_count  <= try_count_next;
      wait_timer <= wait_timer_next;
      discarding <= discarding_next;
    end
  end

  // LFSR: seed write loads, backoff draw advances
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_WIDTH'(1);
    end else if (seed.load) begin
      lfsr <= lfsr_seeded;
    end else if (consume) begin
      lfsr <= lfsr_next;
    end
  end

endmodule

/* rtl/cbt_out_stage.sv */
// ---------------------------------------------------------------------------
// CSMA/CD transmitter output stage
// Holds a group of up to two results and hands them out one per request.
// ---------------------------------------------------------------------------
module cbt_out_stage import cbt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       grp_valid,
  input  res_group_t grp,
  output logic       grp_ready,
  output logic       result_valid,
  input  logic       result_stall,
  output out_item_t  result
);

  out_item_t  slot0;
  out_item_t  slot1;
  logic [1:0] count;
  logic       pop;

  assign result_valid = (count != 2'd0);
  assign result       = slot0;
  assign pop          = result_valid && !result_stall;
  assign grp_ready    = (count == 2'd0) || ((count == 2'd1) && pop);

  // Track how many results are held
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (grp_valid && grp_ready) begin
      count <= grp.cnt;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // Load a new group or shift the second result forward
  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      slot0 <= grp.res0;
      slot1 <= grp.res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

/* rtl/csma_cd_byte_transmitter_unit.sv */
// ---------------------------------------------------------------------------
// CSMA/CD byte transmitter
// Sends offered bytes with carrier sense, collision jam and binary backoff.
// ---------------------------------------------------------------------------
// Usage: the item channel carries byte offers (kind 0) and time ticks
// (kind 1) together with the sensed carrier and collision flags. The result
// channel carries data-sent, jam-sent, abort and byte-done reports; one item
// causes zero, one or two results, the last flagged by last_of_run.
// An item moves through a two-entry command queue into the engine, which
// retires one command per cycle while the output register takes results;
// they land in that two-slot register in the next cycle, so the first
// result shows once the item has passed the queue and the output register.
// Throughput is one item per cycle while items cause at most one result
// with no result stall; jam plus abort holds the engine while both go out.
// Reset clears the phase, counters and queues, restores register defaults
// and loads the LFSR with one. When the result side stalls, the output
// register holds, the engine waits and the queue fills; item_stall rises
// once both queue entries are taken. Configuration writes take effect on
// the next cycle; a seed write also reloads the LFSR.
// ---------------------------------------------------------------------------
module csma_cd_byte_transmitter_unit import cbt_pkg::*; #(
  parameter int unsigned LFSR_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  seed_load_t seed;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_take;
  logic       grp_valid;
  logic       grp_ready;
  res_group_t grp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_tries    <= MAX_TRIES_RST;
      cfg.poll_ticks   <= POLL_TICKS_RST;
      cfg.window_ticks <= WINDOW_TICKS_RST;
      cfg.slot_ticks   <= SLOT_TICKS_RST;
      cfg.backoff_cap  <= BACKOFF_CAP_RST;
      cfg.jam_byte     <= JAM_BYTE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_TRIES:    cfg.max_tries    <= cfg_data[3:0];
        REG_POLL_TICKS:   cfg.poll_ticks   <= cfg_data;
        REG_WINDOW_TICKS: cfg.window_ticks <= cfg_data;
        REG_SLOT_TICKS:   cfg.slot_ticks   <= cfg_data[7:0];
        REG_BACKOFF_CAP:  cfg.backoff_cap  <= cfg_data[3:0];
        REG_JAM_BYTE:     cfg.jam_byte     <= cfg_data[7:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  // Seed write goes straight to the LFSR
  assign seed.load  = cfg_write && (cfg_index == REG_RANDOM_SEED);
  assign seed.value = cfg_data;

  cbt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  cbt_engine #(
    .LFSR_WIDTH (LFSR_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .seed      (seed),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .grp_ready (grp_ready),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  cbt_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .grp_valid    (grp_valid),
    .grp          (grp),
    .grp_ready    (grp_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// CSMA/CD byte transmitter testbench
// Drives byte offers and time ticks through the request channel. An internal
// model predicts every data, jam, abort and done report, and each report is
// checked in order against the result channel. The run covers several
// register settings under varied sender idling and receiver stalls.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cbt_pkg::*;

  localparam int LFSR_W        = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int LIMIT_NS      = 5_000_000;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  in_item_t              item;
  logic                  result_valid;
  logic                  result_stall;
  out_item_t             result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  csma_cd_byte_transmitter_unit #(.LFSR_WIDTH(LFSR_W)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Request traffic bookkeeping
  in_item_t  pending_requests[$];
  out_item_t awaited_reports[$];
  int        n_queued;
  int        n_accepted;
  int        n_failures;
  logic      request_taken;
  int        send_idle_pct;
  int        stall_pct;

  // Transmitter model state and its register copy
  cfg_t              model_cfg;
  phase_t            tx_phase;
  logic [7:0]        tx_byte;
  logic              tx_end;
  logic [3:0]        tx_tries;
  logic [17:0]       tx_timer;
  logic [LFSR_W-1:0] tx_lfsr;
  logic              tx_dropping;
  out_item_t         step_reports[2];
  int                step_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void load_lfsr(logic [15:0] v);
    tx_lfsr = LFSR_W'(v);
    if (tx_lfsr == '0) tx_lfsr = LFSR_W'(1);
  endfunction

  function automatic void note_report(logic [1:0] k, logic [7:0] b);
    step_reports[step_cnt] = '{out_kind: k, out_byte: b, try_number: tx_tries,
                               last_of_run: 1'b0};
    step_cnt++;
  endfunction

  // Check the carrier: poll again later or put the held byte on the line
  function automatic void start_send(logic busy);
    if (busy) begin
      tx_phase = PH_POLL;
      tx_timer = 18'(model_cfg.poll_ticks);
    end else begin
      note_report(RES_DATA, tx_byte);
      tx_phase = PH_WINDOW;
      tx_timer = 18'(model_cfg.window_ticks);
    end
  endfunction

  // Advance the model by one request and queue the reports it causes
  function automatic void transmit_step(in_item_t it);
    logic [3:0]  expo;
    logic [31:0] taps;
    int unsigned rnd;
    step_cnt = 0;
    if (it.kind == KIND_OFFER) begin
      if (tx_phase == PH_IDLE) begin
        if (tx_dropping) begin
          if (it.msg_end) tx_dropping = 1'b0;
        end else begin
          tx_byte  = it.data_byte;
          tx_end   = it.msg_end;
          tx_tries = '0;
          start_send(it.channel_busy);
        end
      end
    end else if (tx_phase != PH_IDLE) begin
      if (tx_timer > 18'd1) begin
        tx_timer--;
      end else begin
        tx_timer = '0;
        if (tx_phase != PH_WINDOW) begin
          start_send(it.channel_busy);
        end else if (!it.collision_seen) begin
          note_report(RES_DONE, 8'd0);
          tx_phase = PH_IDLE;
        end else begin
          if (tx_tries < 4'd15) tx_tries++;
          note_report(RES_JAM, model_cfg.jam_byte);
          if (tx_tries >= model_cfg.max_tries) begin
            note_report(RES_ABORT, 8'd0);
            tx_dropping = !tx_end;
            tx_phase = PH_IDLE;
          end else begin
            // Truncated exponent, then one LFSR step for the slot count
            expo = tx_tries;
            if (expo > model_cfg.backoff_cap) expo = model_cfg.backoff_cap;
            if (expo > EXP_LIMIT) expo = EXP_LIMIT;
            taps = TAP_MASKS[LFSR_W-11];
            tx_lfsr = {tx_lfsr[LFSR_W-2:0], ^(tx_lfsr & taps[LFSR_W-1:0])};
            if (tx_lfsr == '0) tx_lfsr = LFSR_W'(1);
            rnd = 32'(tx_lfsr) & ((32'd1 << expo) - 32'd1);
            tx_timer = 18'(rnd * model_cfg.slot_ticks);
            tx_phase = PH_BACKOFF;
          end
        end
      end
    end
    if (step_cnt > 0) step_reports[step_cnt-1].last_of_run = 1'b1;
    for (int i = 0; i < step_cnt; i++) awaited_reports.push_back(step_reports[i]);
  endfunction

  function automatic void note_failure(string msg);
    if (n_failures < 10) $display("%0t mismatch: %s", $realtime, msg);
    n_failures++;
  endfunction

  // Driver: present requests at the falling edge, hold until taken
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || request_taken) begin
      if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        item       <= pending_requests.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: predict on each taken request, check each taken report
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      request_taken = 1'b0;
    end else begin
      request_taken = item_valid && !item_stall;
      if (request_taken) begin
        transmit_step(item);
        n_accepted++;
      end
      if (result_valid && !result_stall) begin
        if (awaited_reports.size() == 0) begin
          note_failure($sformatf("unexpected report %h", result));
        end else begin
          want = awaited_reports.pop_front();
          if (result.out_kind !== want.out_kind || result.out_byte !== want.out_byte ||
              result.try_number !== want.try_number ||
              result.last_of_run !== want.last_of_run)
            note_failure($sformatf(
              "kind %0d/%0d byte %h/%h try %0d/%0d last %0b/%0b (expected/actual)",
              want.out_kind, result.out_kind, want.out_byte, result.out_byte,
              want.try_number, result.try_number, want.last_of_run,
              result.last_of_run));
        end
      end
    end
  end

  function automatic in_item_t make_offer(logic [7:0] b, logic last, logic busy);
    in_item_t it;
    it = '{kind: KIND_OFFER, data_byte: b, msg_end: last, channel_busy: busy,
           collision_seen: 1'($urandom)};
    return it;
  endfunction

  function automatic in_item_t make_tick(logic busy, logic coll);
    in_item_t it;
    it = '{kind: KIND_TICK, data_byte: 8'($urandom), msg_end: 1'($urandom),
           channel_busy: busy, collision_seen: coll};
    return it;
  endfunction

  task automatic push(in_item_t it);
    pending_requests.push_back(it);
    n_queued++;
  endtask

  task automatic wait_taken();
    while (n_accepted != n_queued) @(negedge clk);
  endtask

  task automatic push_sync(in_item_t it);
    push(it);
    wait_taken();
  endtask

  // Hold the sender until every request is taken and every report is in
  task automatic wait_quiet();
    while (n_accepted != n_queued || awaited_reports.size() != 0) @(negedge clk);
  endtask

  // Bring the block back to idle with quiet ticks, then let it drain
  task automatic settle();
    wait_quiet();
    while (tx_phase != PH_IDLE) push_sync(make_tick(1'b0, 1'b0));
    wait_quiet();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 69; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 69; end
      default: begin send_idle_pct = 18; stall_pct = 18; end
    endcase
  endtask

  task automatic cfg_put(cfg_reg_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_MAX_TRIES:    model_cfg.max_tries    = v[3:0];
      REG_POLL_TICKS:   model_cfg.poll_ticks   = v;
      REG_WINDOW_TICKS: model_cfg.window_ticks = v;
      REG_SLOT_TICKS:   model_cfg.slot_ticks   = v[7:0];
      REG_BACKOFF_CAP:  model_cfg.backoff_cap  = v[3:0];
      REG_JAM_BYTE:     model_cfg.jam_byte     = v[7:0];
      REG_RANDOM_SEED:  load_lfsr(v);
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [3:0] tries, logic [15:0] poll, logic [15:0] win,
                               logic [7:0] slot, logic [3:0] cap, logic [7:0] jam,
                               logic [15:0] seed);
    cfg_put(REG_MAX_TRIES, 16'(tries));
    cfg_put(REG_POLL_TICKS, poll);
    cfg_put(REG_WINDOW_TICKS, win);
    cfg_put(REG_SLOT_TICKS, 16'(slot));
    cfg_put(REG_BACKOFF_CAP, 16'(cap));
    cfg_put(REG_JAM_BYTE, 16'(jam));
    cfg_put(REG_RANDOM_SEED, seed);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed messages: offers followed by runs of ticks,
  // with some raw noise requests mixed in; pause once halfway
  task automatic run_random_phase(int count, int tick_hi);
    int       made;
    int       nbytes;
    int       nticks;
    bit       paused;
    in_item_t noise;
    made   = 0;
    paused = 0;
    while (made < count) begin
      if (!paused && made >= count / 2) begin
        wait_quiet();
        paused = 1;
      end
      if ($urandom_range(0, 99) < 85) begin
        nbytes = $urandom_range(1, 4);
        for (int b = 0; b < nbytes; b++) begin
          push(make_offer(8'($urandom), b == nbytes - 1, $urandom_range(0, 99) < 25));
          made++;
          nticks = $urandom_range(2, tick_hi);
          for (int t = 0; t < nticks; t++) begin
            push(make_tick($urandom_range(0, 99) < 20, $urandom_range(0, 99) < 35));
            made++;
          end
        end
      end else begin
        noise = in_item_t'(12'($urandom));
        push(noise);
        made++;
      end
    end
  endtask

  initial begin
    logic [15:0] win;
    logic [15:0] poll;
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    result_stall  = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    request_taken = 1'b0;
    n_queued      = 0;
    n_accepted    = 0;
    n_failures    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    model_cfg     = '{max_tries: MAX_TRIES_RST, poll_ticks: POLL_TICKS_RST,
                      window_ticks: WINDOW_TICKS_RST, slot_ticks: SLOT_TICKS_RST,
                      backoff_cap: BACKOFF_CAP_RST, jam_byte: JAM_BYTE_RST};
    tx_phase      = PH_IDLE;
    tx_byte       = '0;
    tx_end        = 1'b0;
    tx_tries      = '0;
    tx_timer      = '0;
    tx_dropping   = 1'b0;
    load_lfsr(16'd1);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: idle tick, ignored offer, poll, retry after backoff,
    // abort with discard, discard cleared by message end; zero seed
    set_idling(0);
    load_settings(4'd2, 16'd2, 16'd1, 8'd1, 4'd1, 8'hFF, 16'd0);
    push(make_tick(1'b1, 1'b1));
    push(make_offer(8'h00, 1'b0, 1'b1));
    push(make_offer(8'hFF, 1'b1, 1'b0));
    push(make_tick(1'b1, 1'b0));
    push(make_tick(1'b0, 1'b0));
    push(make_tick(1'b0, 1'b1));
    push(make_tick(1'b0, 1'b0));
    push(make_tick(1'b0, 1'b1));
    push(make_offer(8'h55, 1'b0, 1'b0));
    push(make_offer(8'hAA, 1'b1, 1'b0));
    push(make_offer(8'hFF, 1'b1, 1'b0));
    push(make_tick(1'b1, 1'b0));
    settle();

    // Directed: zero timers, zero try limit, oversized backoff cap,
    // abort on the last byte of a message
    load_settings(4'd0, 16'd0, 16'd0, 8'd0, 4'd15, 8'h5A, 16'hACE1);
    push(make_offer(8'h12, 1'b0, 1'b1));
    push(make_tick(1'b1, 1'b0));
    push(make_tick(1'b0, 1'b0));
    push(make_tick(1'b0, 1'b1));
    push(make_offer(8'h34, 1'b1, 1'b0));
    push(make_offer(8'hC3, 1'b1, 1'b0));
    push(make_tick(1'b0, 1'b1));
    push(make_offer(8'h0F, 1'b0, 1'b0));
    push(make_tick(1'b0, 1'b0));
    settle();

    // Random phases under each idling mode
    for (int p = 0; p < 7; p++) begin
      set_idling(p % 4);
      win  = (p == 3) ? 16'd40 : 16'($urandom_range(1, 5));
      poll = (p == 3) ? 16'd37 : 16'($urandom_range(1, 5));
      load_settings((p == 0) ? 4'd1 : 4'($urandom_range(1, 8)), poll, win,
                    8'($urandom_range(1, 3)),
                    (p == 0) ? 4'd0 : 4'($urandom_range(0, 4)),
                    8'($urandom), 16'($urandom_range(1, 65535)));
      run_random_phase(120, (p == 3) ? 90 : 14);
      settle();
    end

    // Collision on every window: count tries up to the limit,
    // zero-length slots keep each backoff to one tick
    set_idling(0);
    load_settings(4'd15, 16'd1, 16'd1, 8'd0, 4'd15, 8'h00, 16'($urandom_range(1, 65535)));
    push_sync(make_offer(8'($urandom), 1'b0, 1'b0));
    while (tx_phase != PH_IDLE) push_sync(make_tick(1'b0, 1'b1));
    settle();

    // Largest timer settings; the run ends with a byte still in flight
    set_idling(3);
    load_settings(4'd15, 16'd65535, 16'd65535, 8'd255, 4'd10, 8'hFF, 16'd65535);
    run_random_phase(40, 6);

    wait_quiet();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (n_failures == 0 && awaited_reports.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #(LIMIT_NS);
    $display("testbench: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/cbt_pkg.sv
rtl/cbt_front.sv
rtl/cbt_engine.sv
rtl/cbt_out_stage.sv
rtl/csma_cd_byte_transmitter_unit.sv
tb/testbench.sv
